### hdl/htb_pkg.sv
package htb_pkg;

	// line_mode codes
	localparam logic [2:0] MODE_TEXT = 3'd0;
	localparam logic [2:0] MODE_LF   = 3'd1;
	localparam logic [2:0] MODE_CR   = 3'd2;
	localparam logic [2:0] MODE_CRLF = 3'd3;
	localparam logic [2:0] MODE_HEX  = 3'd4;

	localparam logic [7:0] QUOTE_CH = 8'h22;
	localparam logic [7:0] LF_CH    = 8'h0A;
	localparam logic [7:0] CR_CH    = 8'h0D;
	localparam logic [7:0] ZERO_CH  = 8'h30;
	localparam logic [7:0] LOW_X_CH = 8'h78;
	localparam logic [7:0] UP_X_CH  = 8'h58;

	localparam int NUM_SLOTS = 3;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       valid;
		logic       bad;
		logic       oq;
		logic       eom;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_nib_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {8'h20, [8'h09:8'h0D]});
	endfunction

	function automatic hex_nib_t hex_val(input logic [7:0] c);
		hex_nib_t r;
		r.ok  = 1'b1;
		r.nib = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r.nib = c[3:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r.nib = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

### hdl/hex_text_to_bytes_parser.sv
// Channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_stall    | ch[7:0], last_char
// output   | out_valid / out_stall  | out_byte[7:0], byte_valid, bad_hex,
//          |                        | open_quote, end_of_message
// config   | cfg_we                 | cfg_wdata[2:0] (line_mode)
//
// One character is taken per cycle into the input register while in_stall is
// low; it is decoded there and its 0 to 3 results land in the result buffer.
// Hex mode and plain text sustain one transfer per cycle while out_stall is low;
// bytes appended at a line ending leave one at a time by the single output port.
// Reset clears line_mode to plain text and the hex parser to its start state.
// A stalled output holds the buffer; the input stalls only while the waiting
// character has results and the buffer cannot empty in this cycle.
module hex_text_to_bytes_parser
	import htb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       bad_hex,
	output logic       open_quote,
	output logic       end_of_message
);

	logic [2:0] line_mode_q;

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// hex parser state
	logic [7:0] held_char_q;
	logic       has_held_q;
	logic       in_quote_q;
	logic       qjo_q;
	logic       at_start_q;

	// result buffer
	res_t       slot_q [NUM_SLOTS];
	logic [1:0] cnt_q;
	logic [1:0] rd_q;

	// decode outputs
	logic [7:0] held_n;
	logic       has_held_n;
	logic       in_quote_n;
	logic       qjo_n;
	logic       at_start_n;
	res_t       res [NUM_SLOTS];
	logic [1:0] n_res;

	logic       hex_emit;
	logic [7:0] hex_byte;
	logic       hex_bad;
	logic       pfx_skip;
	hex_nib_t   hv_hi;
	hex_nib_t   hv_lo;
	hex_nib_t   hv_tail;

	logic in_xfer, out_xfer, buf_free, advance;

	assign hv_hi   = hex_val(held_char_q);
	assign hv_lo   = hex_val(ch_s1);
	assign hv_tail = hex_val(held_n);

	// Hex step: at most one byte per character.
	always_comb begin
		held_n     = held_char_q;
		has_held_n = has_held_q;
		in_quote_n = in_quote_q;
		qjo_n      = qjo_q;
		at_start_n = at_start_q;
		hex_emit   = 1'b0;
		hex_byte   = ch_s1;
		hex_bad    = 1'b0;
		pfx_skip   = 1'b0;
		if (in_quote_q) begin
			// literal mode: first char always passes, a later quote closes
			if (qjo_q) begin
				qjo_n    = 1'b0;
				hex_emit = 1'b1;
			end else if (ch_s1 == QUOTE_CH) begin
				in_quote_n = 1'b0;
			end else begin
				hex_emit = 1'b1;
			end
		end else if (!is_space(ch_s1)) begin
			if (!has_held_q) begin
				if (ch_s1 == QUOTE_CH) begin
					in_quote_n = 1'b1;
					qjo_n      = 1'b1;
					at_start_n = 1'b0;
				end else begin
					held_n     = ch_s1;
					has_held_n = 1'b1;
				end
			end else begin
				// second half of a pair; drop a leading 0x / 0X
				has_held_n = 1'b0;
				at_start_n = 1'b0;
				pfx_skip   = at_start_q && (held_char_q == ZERO_CH) &&
					(ch_s1 == LOW_X_CH || ch_s1 == UP_X_CH);
				if (!pfx_skip) begin
					hex_emit = 1'b1;
					if (hv_hi.ok && hv_lo.ok) begin
						hex_byte = {hv_hi.nib, hv_lo.nib};
					end else begin
						hex_byte = 8'h00;
						hex_bad  = 1'b1;
					end
				end
			end
		end
	end

	// Build the result list for the waiting character.
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			res[i] = '{byte_val: 8'h00, valid: 1'b1, bad: 1'b0, oq: 1'b0, eom: 1'b0};
		end
		n_res = 2'd0;
		if (line_mode_q == MODE_HEX) begin
			if (hex_emit) begin
				res[0].byte_val = hex_byte;
				res[0].bad      = hex_bad;
				n_res           = 2'd1;
			end else if (last_s1) begin
				n_res = 2'd1;
				if (has_held_n) begin
					// odd digit at the end stands alone
					res[0].byte_val = hv_tail.ok ? {4'h0, hv_tail.nib} : 8'h00;
					res[0].bad      = !hv_tail.ok;
				end else if (qjo_n) begin
					res[0].byte_val = QUOTE_CH;
				end else begin
					res[0].valid = 1'b0;
				end
			end
			if (last_s1) begin
				res[0].eom = 1'b1;
				res[0].oq  = in_quote_n;
			end
		end else begin
			res[0].byte_val = ch_s1;
			n_res           = 2'd1;
			if (last_s1) begin
				case (line_mode_q)
					MODE_LF: begin
						res[1].byte_val = LF_CH;
						n_res           = 2'd2;
					end
					MODE_CR: begin
						res[1].byte_val = CR_CH;
						n_res           = 2'd2;
					end
					MODE_CRLF: begin
						res[1].byte_val = CR_CH;
						res[2].byte_val = LF_CH;
						n_res           = 2'd3;
					end
					default: begin
						n_res = 2'd1;
					end
				endcase
				res[n_res - 2'd1].eom = 1'b1;
			end
		end
	end

	// Handshakes: buffer frees when empty or its final result transfers now.
	assign out_valid = (cnt_q != 2'd0);
	assign out_xfer  = out_valid && !out_stall;
	assign buf_free  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_xfer);
	assign advance   = valid_s1 && ((n_res == 2'd0) || buf_free);
	assign in_stall  = valid_s1 && !advance;
	assign in_xfer   = in_valid && !in_stall;

	assign out_byte       = slot_q[rd_q].byte_val;
	assign byte_valid     = slot_q[rd_q].valid;
	assign bad_hex        = slot_q[rd_q].bad;
	assign open_quote     = slot_q[rd_q].oq;
	assign end_of_message = slot_q[rd_q].eom;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= MODE_TEXT;
		end else if (cfg_we) begin
			line_mode_q <= cfg_wdata;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1   <= ch;
			last_s1 <= last_char;
		end
	end

	// parser state: in hex mode advance once per character, back to start after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q <= 8'h00;
			has_held_q  <= 1'b0;
			in_quote_q  <= 1'b0;
			qjo_q       <= 1'b0;
			at_start_q  <= 1'b1;
		end else if (advance) begin
			if (last_s1) begin
				held_char_q <= 8'h00;
				has_held_q  <= 1'b0;
				in_quote_q  <= 1'b0;
				qjo_q       <= 1'b0;
				at_start_q  <= 1'b1;
			end else if (line_mode_q == MODE_HEX) begin
				held_char_q <= held_n;
				has_held_q  <= has_held_n;
				in_quote_q  <= in_quote_n;
				qjo_q       <= qjo_n;
				at_start_q  <= at_start_n;
			end
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 2'd0;
		end else if (advance && n_res != 2'd0) begin
			cnt_q <= n_res;
			rd_q  <= 2'd0;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_q[i] <= res[i];
			end
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import htb_pkg::*;

	// line_mode codes that the block does not define; they act as plain text
	localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
	localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

	// cycles to let pass after the last result before a register write or the
	// end: the block is two stages deep, so this leaves ample margin
	localparam int SETTLE_CYCLES = 12;
	// cycles without any transfer before the run is called hung
	localparam int QUIET_LIMIT   = 1000;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_style_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       bad_hex;
		logic       open_quote;
		logic       eom;
	} parsed_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       cfg_we         = 1'b0;
	logic [2:0] cfg_wdata      = MODE_TEXT;
	logic       in_valid       = 1'b0;
	logic       in_stall;
	logic [7:0] ch             = 8'h00;
	logic       last_char      = 1'b0;
	logic       out_valid;
	logic       out_stall      = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       bad_hex;
	logic       open_quote;
	logic       end_of_message;

	hex_text_to_bytes_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.ch             (ch),
		.last_char      (last_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.bad_hex        (bad_hex),
		.open_quote     (open_quote),
		.end_of_message (end_of_message)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// characters waiting to be driven, and bytes the parser still owes us
	text_char_t   pending_chars[$];
	parsed_byte_t expected_bytes[$];

	int  pushed_cnt   = 0;
	int  accepted_cnt = 0;
	int  checked_cnt  = 0;
	int  mode_writes  = 0;
	int  fails        = 0;
	int  quiet_cycles = 0;
	int  send_idle_pct  = 0;
	int  stall_pct      = 0;
	bit  in_taken       = 1'b0;

	// ------------------------------------------------------------------
	// Parser shadow: mode register and hex state, as after reset
	// ------------------------------------------------------------------
	logic [2:0] cur_mode      = MODE_TEXT;
	logic [7:0] pend_char     = 8'h00;
	logic       pend_valid    = 1'b0;
	logic       quoted        = 1'b0;
	logic       quote_fresh   = 1'b0;
	logic       at_line_start = 1'b1;

	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// nibble value of an ASCII hex digit, -1 for anything else
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic parsed_byte_t mk_byte(input logic [7:0] b, input logic v,
			input logic bad);
		parsed_byte_t r;
		r.out_byte   = b;
		r.byte_valid = v;
		r.bad_hex    = bad;
		r.open_quote = 1'b0;
		r.eom        = 1'b0;
		return r;
	endfunction

	// Advance the shadow by one accepted character and queue the bytes it yields.
	task automatic parse_char(input logic [7:0] c, input logic last);
		parsed_byte_t batch[$];
		int           hi;
		int           lo;
		logic         oq;
		oq = 1'b0;
		if (cur_mode == MODE_HEX) begin
			if (quoted) begin
				// literal mode: first char after the opening quote always passes
				if (quote_fresh) begin
					quote_fresh = 1'b0;
					batch.push_back(mk_byte(c, 1'b1, 1'b0));
				end else if (c == QUOTE_CH) begin
					quoted = 1'b0;
				end else begin
					batch.push_back(mk_byte(c, 1'b1, 1'b0));
				end
			end else if (!is_blank(c)) begin
				if (!pend_valid) begin
					if (c == QUOTE_CH) begin
						quoted        = 1'b1;
						quote_fresh   = 1'b1;
						at_line_start = 1'b0;
					end else begin
						pend_char  = c;
						pend_valid = 1'b1;
					end
				end else begin
					pend_valid = 1'b0;
					if (at_line_start && pend_char == ZERO_CH &&
							(c == LOW_X_CH || c == UP_X_CH)) begin
						// drop the leading 0x prefix
						at_line_start = 1'b0;
					end else begin
						at_line_start = 1'b0;
						hi = nibble_of(pend_char);
						lo = nibble_of(c);
						if (hi < 0 || lo < 0)
							batch.push_back(mk_byte(8'h00, 1'b1, 1'b1));
						else
							batch.push_back(mk_byte({hi[3:0], lo[3:0]}, 1'b1, 1'b0));
					end
				end
			end
		end else begin
			batch.push_back(mk_byte(c, 1'b1, 1'b0));
			if (last) begin
				case (cur_mode)
					MODE_LF: batch.push_back(mk_byte(LF_CH, 1'b1, 1'b0));
					MODE_CR: batch.push_back(mk_byte(CR_CH, 1'b1, 1'b0));
					MODE_CRLF: begin
						batch.push_back(mk_byte(CR_CH, 1'b1, 1'b0));
						batch.push_back(mk_byte(LF_CH, 1'b1, 1'b0));
					end
					default: ;
				endcase
			end
		end

		if (last) begin
			if (cur_mode == MODE_HEX) begin
				// flush an odd trailing digit, then a dangling opening quote
				if (pend_valid) begin
					hi = nibble_of(pend_char);
					if (hi < 0)
						batch.push_back(mk_byte(8'h00, 1'b1, 1'b1));
					else
						batch.push_back(mk_byte({4'h0, hi[3:0]}, 1'b1, 1'b0));
				end
				if (quote_fresh)
					batch.push_back(mk_byte(QUOTE_CH, 1'b1, 1'b0));
				oq = quoted;
			end
			pend_char     = 8'h00;
			pend_valid    = 1'b0;
			quoted        = 1'b0;
			quote_fresh   = 1'b0;
			at_line_start = 1'b1;
			if (batch.size() == 0)
				batch.push_back(mk_byte(8'h00, 1'b0, 1'b0));
			batch[batch.size() - 1].open_quote = oq;
			batch[batch.size() - 1].eom        = 1'b1;
		end

		foreach (batch[i])
			expected_bytes.push_back(batch[i]);
	endtask

	// ------------------------------------------------------------------
	// Driver: inputs change on the falling edge only
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		text_char_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			// hold a stalled transfer; otherwise offer the next char or idle
			if (!in_valid || in_taken) begin
				if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_chars.pop_front();
					in_valid  <= 1'b1;
					ch        <= nxt.ch;
					last_char <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both channels on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		parsed_byte_t want;
		if (!arst_n) begin
			in_taken = 1'b0;
		end else begin
			// compare first: a byte leaving now cannot come from a char entering now
			if (out_valid && !out_stall) begin
				checked_cnt++;
				if (expected_bytes.size() == 0) begin
					$error("transfer with nothing expected: out_byte %h", out_byte);
					fails++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, out_byte);
						fails++;
					end
					if (byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %b, got %b", want.byte_valid, byte_valid);
						fails++;
					end
					if (bad_hex !== want.bad_hex) begin
						$error("bad_hex: expected %b, got %b", want.bad_hex, bad_hex);
						fails++;
					end
					if (open_quote !== want.open_quote) begin
						$error("open_quote: expected %b, got %b", want.open_quote, open_quote);
						fails++;
					end
					if (end_of_message !== want.eom) begin
						$error("end_of_message: expected %b, got %b", want.eom,
							end_of_message);
						fails++;
					end
				end
			end
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				accepted_cnt++;
				parse_char(ch, last_char);
			end
			if (in_taken || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog: end a run that has stopped moving
	always @(negedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_char(input logic [7:0] c, input logic last);
		text_char_t t;
		t.ch   = c;
		t.last = last;
		pending_chars.push_back(t);
		pushed_cnt++;
	endtask

	// Wait until every char is in and every byte out, then let the pipe settle.
	task automatic drain();
		do @(negedge clk);
		while (accepted_cnt != pushed_cnt || expected_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write line_mode while idle; the shadow follows once the write edge passed.
	task automatic write_mode(input logic [2:0] m);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_mode   = m;
		mode_writes++;
	endtask

	task automatic set_idle(input idle_style_t style);
		case (style)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 75; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 75; end
			default:       begin send_idle_pct = 22; stall_pct = 22; end
		endcase
	endtask

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? 8'h20 : 8'h09 + r[7:0];
	endfunction

	function automatic logic [7:0] rand_hex_digit();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return 8'h30 + r[7:0];
		if (r < 16) return 8'h61 + r[7:0] - 8'd10;
		return 8'h41 + r[7:0] - 8'd16;
	endfunction

	function automatic logic [7:0] rand_literal();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == QUOTE_CH);
		return c;
	endfunction

	// Mostly well-formed hex lines with random content; the rest broken pairs
	// and raw noise. Some lines are left open so the next one continues them.
	task automatic gen_hex_message();
		logic [7:0] msg[$];
		int         kind;
		int         sel;
		bit         terminate;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			if ($urandom_range(0, 2) == 0) begin
				msg.push_back(ZERO_CH);
				msg.push_back($urandom_range(0, 1) ? UP_X_CH : LOW_X_CH);
			end
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 4) == 0) begin
					msg.push_back(QUOTE_CH);
					repeat ($urandom_range(1, 3)) msg.push_back(rand_literal());
					if ($urandom_range(0, 4) != 0) msg.push_back(QUOTE_CH);
				end else begin
					msg.push_back(rand_hex_digit());
					if ($urandom_range(0, 5) == 0) msg.push_back(rand_blank());
					msg.push_back(rand_hex_digit());
				end
				if ($urandom_range(0, 3) == 0) msg.push_back(rand_blank());
			end
			if ($urandom_range(0, 3) == 0) msg.push_back(rand_hex_digit());
		end else if (kind < 9) begin
			repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				sel = $urandom_range(0, 3);
				case (sel)
					0:       msg.push_back(QUOTE_CH);
					1:       msg.push_back(rand_blank());
					2:       msg.push_back(rand_hex_digit());
					default: msg.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
		terminate = ($urandom_range(0, 5) != 0);
		foreach (msg[i])
			push_char(msg[i], terminate && i == msg.size() - 1);
	endtask

	task automatic gen_text_message();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			push_char(8'($urandom_range(0, 255)), i == n - 1);
	endtask

	task automatic run_phase(input logic [2:0] m, input idle_style_t style,
			input int n_items);
		int start;
		write_mode(m);
		set_idle(style);
		start = pushed_cnt;
		while (pushed_cnt - start < n_items) begin
			if (m == MODE_HEX) gen_hex_message();
			else gen_text_message();
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Sequence: reset, directed cases, then random phases
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_idle(IDLE_NONE);

		// plain text at both byte extremes
		write_mode(MODE_TEXT);
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b1);
		drain();

		// single char followed by CR LF
		write_mode(MODE_CRLF);
		push_char("Z", 1'b1);
		drain();

		write_mode(MODE_HEX);
		// 0x prefix dropped, mixed-case pair
		push_char(ZERO_CH, 1'b0);
		push_char(LOW_X_CH, 1'b0);
		push_char("a", 1'b0);
		push_char("B", 1'b1);
		// quote right after opening passes, third closes: end marker only after
		push_char(QUOTE_CH, 1'b0);
		push_char(QUOTE_CH, 1'b0);
		push_char(QUOTE_CH, 1'b1);
		// lone quote as last char: quote byte sent and flagged open
		push_char(QUOTE_CH, 1'b1);
		// quote as second half of a pair, then a bad odd digit at the end
		push_char("1", 1'b0);
		push_char(QUOTE_CH, 1'b0);
		push_char("G", 1'b1);
		// blanks dropped outside quotes, odd digit closes the line
		push_char(8'h09, 1'b0);
		push_char(8'h20, 1'b0);
		push_char(8'h0D, 1'b0);
		push_char("7", 1'b1);
		// blanks kept inside quotes, quote never closed
		push_char(QUOTE_CH, 1'b0);
		push_char("a", 1'b0);
		push_char(8'h20, 1'b0);
		push_char(8'hFF, 1'b1);
		// open a quote, yields nothing yet
		push_char(QUOTE_CH, 1'b0);
		drain();

		// mode change mid-line: hex state must survive a text char
		write_mode(MODE_TEXT);
		push_char("k", 1'b0);
		drain();
		write_mode(MODE_HEX);
		push_char("m", 1'b1);
		drain();

		// random phases across every mode and idle pattern
		run_phase(MODE_HEX, IDLE_NONE, 10);
		run_phase(MODE_HEX, IDLE_SENDER, 10);
		run_phase(MODE_LF, IDLE_RECEIVER, 4);
		run_phase(MODE_HEX, IDLE_RECEIVER, 10);
		run_phase(MODE_CR, IDLE_BOTH, 4);
		run_phase(MODE_HEX, IDLE_BOTH, 10);
		run_phase(MODE_CRLF, IDLE_SENDER, 4);
		run_phase(MODE_UNDEF_HI, IDLE_BOTH, 4);
		run_phase(MODE_TEXT, IDLE_NONE, 4);
		run_phase(3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI)), IDLE_RECEIVER, 4);
		run_phase(MODE_HEX, IDLE_BOTH, 10);

		fails += expected_bytes.size();
		$display("tb: %0d characters sent, %0d bytes compared, %0d line_mode writes",
			accepted_cnt, checked_cnt, mode_writes);
		$display("tb: covered text, LF, CR, CRLF, hex and undefined modes");
		$display("tb: under four idle patterns");
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
